// File: src/trd_pkg.sv
package trd_pkg;

  // default sizes
  localparam int MaxWidthDef     = 64;
  localparam int MaxHeightDef    = 64;
  localparam int SubpixelBitsDef = 4;

  // datapath widths, sized for the largest supported viewport and subpixel count
  localparam int DIM_W  = 11;  // viewport size up to 1024
  localparam int OPD_W  = 24;  // doubled coordinate differences
  localparam int MUL_W  = 28;  // shared multiplier operand
  localparam int PROD_W = 2 * MUL_W;
  localparam int E_W    = 50;  // edge values
  localparam int W_W    = 52;  // doubled area
  localparam int ACC_W  = 72;  // weighted sums and divider remainder
  localparam int CHUNK  = 25;  // low part of an edge value fed to the multiplier
  localparam int Q_W    = 16;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 2'd1;

  localparam logic [1:0] OP_VERTEX = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [47:0] CLEAR_WORD = {8'hff, 24'h000000, 16'h7fff};

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] depth_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         opacity;
    logic [5:0]         pixel_col;
    logic [5:0]         pixel_row;
  } req_t;

  typedef struct packed {
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic [7:0]         out_opacity;
    logic signed [15:0] out_depth;
    logic               in_view;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EDGE,
    ST_AREA,
    ST_BOX,
    ST_PIX,
    ST_COVER,
    ST_MAC,
    ST_BIAS,
    ST_DIV,
    ST_POST,
    ST_WRITE,
    ST_NEXT
  } state_t;

endpackage

// File: src/triangle_raster_depth_test.sv
// Triangle rasterizer with a depth-tested frame store of MAX_WIDTH x MAX_HEIGHT
// pixels (colour and depth in one on-chip memory, addressed row*MAX_WIDTH+col).
// Vertex requests are gathered three at a time; the third one starts a walk
// over the triangle's bounding box, clipped to the viewport set by the two
// config registers. Both windings are drawn, zero-area triangles are dropped.
// All arithmetic runs through one shared 28x28 multiplier and one restoring
// divider (one quotient bit per cycle) under a small sequencer, and the block
// holds req_ready low while it works. For a closing vertex the sequencer first
// sets up the triangle, then walks the pixels of the clipped box: a covered
// pixel runs the divider for its depth, and a pixel that passes the depth test
// runs it for the four colour channels as well and is written. After reset
// and after each clear request the store is swept one word per cycle, with
// req_ready low; config writes are always taken.
module triangle_raster_depth_test #(
  parameter int MAX_WIDTH     = trd_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT    = trd_pkg::MaxHeightDef,
  parameter int SUBPIXEL_BITS = trd_pkg::SubpixelBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  trd_pkg::req_t                 req_data,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output trd_pkg::rsp_t                 rsp_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [trd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [6:0]                    cfg_data
);
  import trd_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // config registers and effective viewport
  logic [6:0]       view_width, view_height;
  logic [DIM_W-1:0] eff_w, eff_h;

  // sequencer
  state_t state, state_next;
  logic [3:0] step;
  logic [2:0] ch;      // 0 depth, 1..4 red green blue alpha
  logic       setup;   // edge pass evaluated at the origin gives the area
  logic       neg;

  // pending vertices
  logic [1:0]         vcount;
  logic signed [15:0] vpx [3];
  logic signed [15:0] vpy [3];
  logic signed [15:0] vpz [3];
  logic [7:0]         vcol [3][4];

  // walk state
  logic [COL_W-1:0] col, lo_x, hi_x;
  logic [ROW_W-1:0] row, hi_y;

  // arithmetic
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod, tmp;
  logic signed [E_W-1:0]    e [3];
  logic [W_W-1:0]           wsum;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         rem, dvs;
  logic [Q_W-1:0]           q;
  logic signed [15:0]       depth_new;
  logic [7:0]               shade [4];

  // frame store
  logic [47:0]       mem [DEPTH];
  logic [47:0]       mem_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] wr_addr, rd_addr, pix_addr, clr_addr, req_addr;
  logic              req_in_view, rd_in_view;

  // output register
  rsp_t rsp_reg;

  // combinational helpers
  logic signed [OPD_W-1:0] px, py;
  logic signed [OPD_W-1:0] dx [3];
  logic signed [OPD_W-1:0] dy [3];
  logic [1:0]              kk, ia, ib;
  logic [2:0]              sp;
  logic signed [E_W+1:0]   area;
  logic signed [16:0]      bx_lo, bx_hi, by_lo, by_hi, wm1, hm1;
  logic signed [15:0]      mnx, mxx, mny, mxy;
  logic                    box_empty, covered, div_ge;
  logic signed [15:0]      depth_q;
  logic                    req_fire;

  assign req_fire = req_valid && req_ready;
  assign cfg_ready = 1'b1;

  assign eff_w = ({4'd0, view_width} > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                         : {4'd0, view_width};
  assign eff_h = ({4'd0, view_height} > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                           : {4'd0, view_height};

  // sample point, at the origin during setup
  assign px = setup ? '0 : (OPD_W'({col, 1'b1}) << SUBPIXEL_BITS);
  assign py = setup ? '0 : (OPD_W'({row, 1'b1}) << SUBPIXEL_BITS);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dx[k] = {{(OPD_W-17){vpx[k][15]}}, vpx[k], 1'b0} - px;
      dy[k] = {{(OPD_W-17){vpy[k][15]}}, vpy[k], 1'b0} - py;
    end
  end

  assign kk = step[2:1];
  assign sp = step[2:0] - 3'd1;

  always_comb begin
    case (kk)
      2'd0: begin ia = 2'd1; ib = 2'd2; end
      2'd1: begin ia = 2'd2; ib = 2'd0; end
      2'd2: begin ia = 2'd0; ib = 2'd1; end
      default: begin ia = 2'd0; ib = 2'd0; end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_EDGE && kk != 2'd3) begin
      if (step[0]) begin
        mul_a = {{(MUL_W-OPD_W){dy[ia][OPD_W-1]}}, dy[ia]};
        mul_b = {{(MUL_W-OPD_W){dx[ib][OPD_W-1]}}, dx[ib]};
      end else begin
        mul_a = {{(MUL_W-OPD_W){dx[ia][OPD_W-1]}}, dx[ia]};
        mul_b = {{(MUL_W-OPD_W){dy[ib][OPD_W-1]}}, dy[ib]};
      end
    end else if (state == ST_MAC && kk != 2'd3) begin
      if (ch == 3'd0) begin
        mul_a = {{(MUL_W-16){vpz[kk][15]}}, vpz[kk]};
      end else begin
        mul_a = {{(MUL_W-8){1'b0}}, vcol[kk][ch[1:0] - 2'd1]};
      end
      // edge values are non-negative here, split into two unsigned chunks
      if (step[0]) begin
        mul_b = MUL_W'(e[kk][E_W-1:CHUNK]);
      end else begin
        mul_b = MUL_W'(e[kk][CHUNK-1:0]);
      end
    end
  end

  assign area = (E_W+2)'(e[0]) + (E_W+2)'(e[1]) + (E_W+2)'(e[2]);
  assign covered = !e[0][E_W-1] && !e[1][E_W-1] && !e[2][E_W-1];
  assign div_ge = (rem >= dvs);
  assign depth_q = {~q[Q_W-1], q[Q_W-2:0]};

  // bounding box, floored to whole pixels and clipped to the viewport
  always_comb begin
    mnx = vpx[0]; mxx = vpx[0]; mny = vpy[0]; mxy = vpy[0];
    for (int k = 1; k < 3; k++) begin
      if (vpx[k] < mnx) mnx = vpx[k];
      if (vpx[k] > mxx) mxx = vpx[k];
      if (vpy[k] < mny) mny = vpy[k];
      if (vpy[k] > mxy) mxy = vpy[k];
    end
    wm1 = $signed({6'd0, eff_w}) - 17'sd1;
    hm1 = $signed({6'd0, eff_h}) - 17'sd1;
    bx_lo = 17'(mnx >>> SUBPIXEL_BITS);
    bx_hi = 17'(mxx >>> SUBPIXEL_BITS);
    by_lo = 17'(mny >>> SUBPIXEL_BITS);
    by_hi = 17'(mxy >>> SUBPIXEL_BITS);
    if (bx_lo < 0) bx_lo = '0;
    if (by_lo < 0) by_lo = '0;
    if (bx_hi > wm1) bx_hi = wm1;
    if (by_hi > hm1) by_hi = hm1;
    box_empty = (bx_lo > bx_hi) || (by_lo > by_hi);
  end

  assign pix_addr = ADDR_W'(int'(row) * MAX_WIDTH + int'(col));
  assign req_addr = ADDR_W'(int'(req_data.pixel_row) * MAX_WIDTH + int'(req_data.pixel_col));
  assign req_in_view = ({5'd0, req_data.pixel_col} < eff_w) &&
                       ({5'd0, req_data.pixel_row} < eff_h);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (req_fire) begin
          case (req_data.operation)
            OP_VERTEX: if (vcount == 2'd2) state_next = ST_EDGE;
            OP_CLEAR:  state_next = ST_CLEAR;
            OP_READ:   state_next = ST_READ;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      ST_EDGE: if (step == 4'd6) state_next = setup ? ST_AREA : ST_COVER;
      ST_AREA: begin
        if (area == 0 || eff_w == '0 || eff_h == '0) state_next = ST_IDLE;
        else state_next = ST_BOX;
      end
      ST_BOX:   state_next = box_empty ? ST_IDLE : ST_PIX;
      ST_PIX:   state_next = ST_EDGE;
      ST_COVER: state_next = covered ? ST_MAC : ST_NEXT;
      ST_MAC:   if (step == 4'd6) state_next = ST_BIAS;
      ST_BIAS:  state_next = ST_DIV;
      ST_DIV:   if (step == 4'd15) state_next = ST_POST;
      ST_POST: begin
        if (ch == 3'd0) state_next = (depth_q < $signed(mem_q[15:0])) ? ST_MAC : ST_NEXT;
        else if (ch == 3'd4) state_next = ST_WRITE;
        else state_next = ST_MAC;
      end
      ST_WRITE: state_next = ST_NEXT;
      ST_NEXT: begin
        if (col == hi_x && row == hi_y) state_next = ST_IDLE;
        else state_next = ST_PIX;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_ready = (state == ST_IDLE);
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    wr_addr   = pix_addr;
    rd_addr   = pix_addr;
    case (state)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_addr;
      end
      ST_IDLE: begin
        mem_re  = req_fire && (req_data.operation == OP_READ);
        rd_addr = req_addr;
      end
      ST_PIX:   mem_re = 1'b1;
      ST_WRITE: mem_we = 1'b1;
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // frame store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= (state == ST_CLEAR) ? CLEAR_WORD
                      : {shade[3], shade[2], shade[1], shade[0], depth_new};
    end
    if (mem_re) begin
      mem_q <= mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      vcount      <= '0;
      view_width  <= 7'd64;
      view_height <= 7'd64;
      rsp_valid   <= 1'b0;
      step        <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VIEW_WIDTH:  view_width <= cfg_data;
          REG_VIEW_HEIGHT: view_height <= cfg_data;
          default: begin
            view_width <= view_width;
          end
        endcase
      end
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      else clr_addr <= '0;
      if (req_fire && req_data.operation == OP_VERTEX) begin
        vcount <= (vcount == 2'd2) ? 2'd0 : vcount + 2'd1;
      end
      if (state == ST_READ && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      // step counter restarts whenever the sequencer changes state
      if (state_next != state) step <= '0;
      else step <= step + 4'd1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (req_fire && req_data.operation == OP_VERTEX) begin
      vpx[vcount] <= req_data.pos_x;
      vpy[vcount] <= req_data.pos_y;
      vpz[vcount] <= req_data.depth_z;
      vcol[vcount][0] <= req_data.red;
      vcol[vcount][1] <= req_data.green;
      vcol[vcount][2] <= req_data.blue;
      vcol[vcount][3] <= req_data.opacity;
      setup <= 1'b1;
      neg   <= 1'b0;
    end
    if (req_fire) rd_in_view <= req_in_view;

    if (state == ST_READ && (!rsp_valid || rsp_ready)) begin
      if (rd_in_view) begin
        rsp_reg.out_red     <= mem_q[23:16];
        rsp_reg.out_green   <= mem_q[31:24];
        rsp_reg.out_blue    <= mem_q[39:32];
        rsp_reg.out_opacity <= mem_q[47:40];
        rsp_reg.out_depth   <= mem_q[15:0];
        rsp_reg.in_view     <= 1'b1;
      end else begin
        rsp_reg <= '0;
      end
    end

    // two products per edge, subtracted as the second one lands
    if (state == ST_EDGE || state == ST_MAC) prod <= mul_a * mul_b;
    if (state == ST_EDGE && step != 4'd0) begin
      if (!sp[0]) tmp <= prod;
      else e[sp[2:1]] <= neg ? E_W'(prod - tmp) : E_W'(tmp - prod);
    end

    if (state == ST_AREA) begin
      neg   <= area < 0;
      wsum  <= (area < 0) ? W_W'(-area) : W_W'(area);
      setup <= 1'b0;
    end

    if (state == ST_BOX) begin
      lo_x <= COL_W'(bx_lo);
      hi_x <= COL_W'(bx_hi);
      hi_y <= ROW_W'(by_hi);
      col  <= COL_W'(bx_lo);
      row  <= ROW_W'(by_lo);
    end

    if (state == ST_COVER) ch <= '0;

    // weighted sum: low chunk then high chunk for each vertex
    if (state == ST_MAC) begin
      if (step == 4'd0) acc <= '0;
      else if (!sp[0]) acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      else acc <= acc + ({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod} << CHUNK);
    end

    // bias by 32768*w for a non-negative dividend, plus w/2 for rounding
    if (state == ST_BIAS) begin
      rem <= ACC_W'(acc) + (ACC_W'(wsum) << 15) + ACC_W'(wsum >> 1);
      dvs <= ACC_W'(wsum) << (Q_W - 1);
      q   <= '0;
    end

    if (state == ST_DIV) begin
      if (div_ge) rem <= rem - dvs;
      q   <= {q[Q_W-2:0], div_ge};
      dvs <= dvs >> 1;
    end

    if (state == ST_POST) begin
      if (ch == 3'd0) depth_new <= depth_q;
      else shade[ch[1:0] - 2'd1] <= q[7:0];
      ch <= ch + 3'd1;
    end

    if (state == ST_NEXT) begin
      setup <= 1'b0;
      if (col == hi_x) begin
        col <= lo_x;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  assign rsp_data = rsp_reg;

endmodule

// File: src/trd_checker.sv
module trd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input trd_pkg::req_t                 req_data,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input trd_pkg::rsp_t                 rsp_data,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [trd_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [6:0]                    cfg_data
);
  import trd_pkg::*;

  // store sweep keeps requests out right after reset
  a_reset_sweep: assert property (@(posedge clk) !rst && $past(rst) |-> !req_ready)
    else $error("request taken during reset sweep");

  // after a read is taken, req_ready is low in the next cycle
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_data.operation == OP_READ |=> !req_ready)
    else $error("request taken while read pending");

  // outside the viewport everything reads as zero
  a_out_view: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.in_view |-> rsp_data.out_red == 8'd0 &&
    rsp_data.out_green == 8'd0 && rsp_data.out_blue == 8'd0 &&
    rsp_data.out_opacity == 8'd0 && rsp_data.out_depth == 16'sd0)
    else $error("nonzero response outside viewport");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response dropped while stalled");

endmodule

bind triangle_raster_depth_test trd_checker u_trd_checker (.*);

// File: bench/tb.sv
`default_nettype none

class raster_scoreboard;
  localparam int MW = 64;
  localparam int MH = 64;
  localparam int SUB = 4;

  int vw, vh;
  int vert_x[3], vert_y[3], vert_z[3];
  int vert_rgba[3][4];
  int nvert;
  logic [31:0] colour_mem[MW*MH];
  logic [15:0] depth_mem[MW*MH];
  trd_pkg::rsp_t pixels_due[$];
  int errors;

  function new();
    vw = 64;
    vh = 64;
    nvert = 0;
    errors = 0;
    wipe();
  endfunction

  function void wipe();
    foreach (colour_mem[i]) begin
      colour_mem[i] = 32'hff000000;
      depth_mem[i] = 16'h7fff;
    end
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function void set_reg(logic [1:0] idx, logic [6:0] v);
    if (idx == trd_pkg::REG_VIEW_WIDTH) vw = v;
    else if (idx == trd_pkg::REG_VIEW_HEIGHT) vh = v;
  endfunction

  function int eff_w();
    return vw > MW ? MW : vw;
  endfunction

  function int eff_h();
    return vh > MH ? MH : vh;
  endfunction

  // round half up of s / w, w > 0
  function int blend(longint s, longint w);
    longint b;
    b = s + 64'sd32768 * w + w / 2;
    return int'(b / w) - 32768;
  endfunction

  function void draw();
    longint dx[3], dy[3], e[3], area, cx, cy, wsum, acc;
    int lx, hx, ly, hy, w, h, z, idx;
    logic [31:0] rgba;
    w = eff_w();
    h = eff_h();
    if (w == 0 || h == 0) return;
    for (int k = 0; k < 3; k++) begin
      dx[k] = 2 * longint'(vert_x[k]);
      dy[k] = 2 * longint'(vert_y[k]);
    end
    area = (dx[1] - dx[0]) * (dy[2] - dy[0]) - (dy[1] - dy[0]) * (dx[2] - dx[0]);
    if (area == 0) return;
    lx = vert_x[0]; hx = vert_x[0]; ly = vert_y[0]; hy = vert_y[0];
    for (int k = 1; k < 3; k++) begin
      if (vert_x[k] < lx) lx = vert_x[k];
      if (vert_x[k] > hx) hx = vert_x[k];
      if (vert_y[k] < ly) ly = vert_y[k];
      if (vert_y[k] > hy) hy = vert_y[k];
    end
    lx = lx >>> SUB; hx = hx >>> SUB; ly = ly >>> SUB; hy = hy >>> SUB;
    if (lx < 0) lx = 0;
    if (ly < 0) ly = 0;
    if (hx > w - 1) hx = w - 1;
    if (hy > h - 1) hy = h - 1;
    for (int row = ly; row <= hy; row++) begin
      for (int col = lx; col <= hx; col++) begin
        cx = longint'((2 * col + 1) << SUB);
        cy = longint'((2 * row + 1) << SUB);
        e[0] = (dx[1] - cx) * (dy[2] - cy) - (dy[1] - cy) * (dx[2] - cx);
        e[1] = (dx[2] - cx) * (dy[0] - cy) - (dy[2] - cy) * (dx[0] - cx);
        e[2] = (dx[0] - cx) * (dy[1] - cy) - (dy[0] - cy) * (dx[1] - cx);
        if (area < 0) begin
          e[0] = -e[0]; e[1] = -e[1]; e[2] = -e[2];
        end
        if (e[0] < 0 || e[1] < 0 || e[2] < 0) continue;
        wsum = e[0] + e[1] + e[2];
        acc = 0;
        for (int k = 0; k < 3; k++) acc += longint'(vert_z[k]) * e[k];
        z = blend(acc, wsum);
        idx = row * MW + col;
        if (z >= int'($signed(depth_mem[idx]))) continue;
        for (int c = 0; c < 4; c++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += longint'(vert_rgba[k][c]) * e[k];
          rgba[8*c +: 8] = 8'(blend(acc, wsum));
        end
        colour_mem[idx] = rgba;
        depth_mem[idx] = 16'(z);
      end
    end
  endfunction

  // accepted request: update the frame store copy, queue a pixel for reads
  function void note(trd_pkg::req_t r);
    trd_pkg::rsp_t px;
    int idx;
    case (r.operation)
      trd_pkg::OP_VERTEX: begin
        vert_x[nvert] = r.pos_x;
        vert_y[nvert] = r.pos_y;
        vert_z[nvert] = r.depth_z;
        vert_rgba[nvert][0] = r.red;
        vert_rgba[nvert][1] = r.green;
        vert_rgba[nvert][2] = r.blue;
        vert_rgba[nvert][3] = r.opacity;
        if (nvert == 2) begin
          draw();
          nvert = 0;
        end else begin
          nvert++;
        end
      end
      trd_pkg::OP_CLEAR: wipe();
      trd_pkg::OP_READ: begin
        px = '0;
        if (r.pixel_col < eff_w() && r.pixel_row < eff_h()) begin
          idx = r.pixel_row * MW + r.pixel_col;
          px.out_red = colour_mem[idx][7:0];
          px.out_green = colour_mem[idx][15:8];
          px.out_blue = colour_mem[idx][23:16];
          px.out_opacity = colour_mem[idx][31:24];
          px.out_depth = depth_mem[idx];
          px.in_view = 1'b1;
        end
        pixels_due.push_back(px);
      end
      default: ;
    endcase
  endfunction

  task check(trd_pkg::rsp_t got);
    trd_pkg::rsp_t exp;
    if (pixels_due.size() == 0) begin
      report("pixel returned with no read outstanding");
      return;
    end
    exp = pixels_due.pop_front();
    if (got.out_red !== exp.out_red)
      report($sformatf("red %0d, want %0d", got.out_red, exp.out_red));
    if (got.out_green !== exp.out_green)
      report($sformatf("green %0d, want %0d", got.out_green, exp.out_green));
    if (got.out_blue !== exp.out_blue)
      report($sformatf("blue %0d, want %0d", got.out_blue, exp.out_blue));
    if (got.out_opacity !== exp.out_opacity)
      report($sformatf("alpha %0d, want %0d", got.out_opacity, exp.out_opacity));
    if (got.out_depth !== exp.out_depth)
      report($sformatf("depth %0d, want %0d", got.out_depth, exp.out_depth));
    if (got.in_view !== exp.in_view)
      report($sformatf("in_view %0b, want %0b", got.in_view, exp.in_view));
  endtask
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trd_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  raster_scoreboard frame = new();

  // idle percentages for the request side and the pixel return side
  int send_idle = 0;
  int take_idle = 0;
  // pixel area recent triangles were placed in, so reads hit drawn pixels
  int spot_x = 0;
  int spot_y = 0;

  triangle_raster_depth_test DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data(rsp_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // return side: random back-pressure, checks each returned pixel
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= take_idle);
    if (!rst && rsp_valid && rsp_ready) frame.check(rsp_data);
  end

  // valid stays high between back-to-back requests, it only drops for a gap
  task automatic send(req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle && gap < 12) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    do @(posedge clk); while (!req_ready);
    frame.note(r);
  endtask

  task automatic vertex(int x, int y, int z, int rd, int gr, int bl, int al);
    req_t r;
    r = '0;
    r.operation = OP_VERTEX;
    r.pos_x = 16'(x);
    r.pos_y = 16'(y);
    r.depth_z = 16'(z);
    r.red = 8'(rd);
    r.green = 8'(gr);
    r.blue = 8'(bl);
    r.opacity = 8'(al);
    r.pixel_col = 6'($urandom);
    r.pixel_row = 6'($urandom);
    send(r);
  endtask

  task automatic read_px(int col, int row);
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom, $urandom});
    r.operation = OP_READ;
    r.pixel_col = 6'(col);
    r.pixel_row = 6'(row);
    send(r);
  endtask

  task automatic clear_all();
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom, $urandom});
    r.operation = OP_CLEAR;
    send(r);
  endtask

  // a read can only be taken once a triangle walk is over, so its pixel
  // coming back means the block is idle
  task automatic settle();
    read_px(0, 0);
    req_valid <= 1'b0;
    while (frame.pixels_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    frame.set_reg(idx, v);
  endtask

  task automatic set_view(int w, int h);
    write_reg(REG_VIEW_WIDTH, 7'(w));
    write_reg(REG_VIEW_HEIGHT, 7'(h));
    // indexes past the two registers are ignored
    write_reg(2'd2 + CFG_IDX_W'($urandom_range(1)), 7'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic small_vertex();
    vertex(spot_x * 16 + $urandom_range(0, 63) - 8, spot_y * 16 + $urandom_range(0, 63) - 8,
           $urandom_range(0, 65535) - 32768, $urandom_range(255), $urandom_range(255),
           $urandom_range(255), $urandom_range(255));
  endtask

  // random requests, mostly whole small triangles near a moving spot
  task automatic random_mix(int count);
    int sent, pick, kind, xs, ys;
    req_t r;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        clear_all();
        sent++;
      end else if (pick < 5) begin
        // unused operation code, no effect
        r = req_t'({$urandom, $urandom, $urandom, $urandom});
        r.operation = OP_NONE;
        send(r);
      end else if (pick < 32) begin
        if ($urandom_range(3) != 0)
          read_px(spot_x + $urandom_range(0, 4), spot_y + $urandom_range(0, 4));
        else
          read_px($urandom_range(63), $urandom_range(63));
        sent++;
      end else begin
        kind = $urandom_range(9);
        spot_x = $urandom_range(0, 66) - 2;
        spot_y = $urandom_range(0, 66) - 2;
        for (int k = 0; k < 3; k++) begin
          if (kind < 8) begin
            small_vertex();
          end else if (kind == 8) begin
            // far off screen, exercising the high position bits cheaply
            xs = $urandom_range(1) ? $urandom_range(0, 32752) - 32768
                                   : $urandom_range(1100, 32767);
            ys = $urandom_range(0, 65535) - 32768;
            if ($urandom_range(1)) vertex(ys, xs, $urandom_range(0, 65535) - 32768,
                                          $urandom_range(255), $urandom_range(255),
                                          $urandom_range(255), $urandom_range(255));
            else vertex(xs, ys, $urandom_range(0, 65535) - 32768, $urandom_range(255),
                        $urandom_range(255), $urandom_range(255), $urandom_range(255));
          end else begin
            // points on one line, dropped as zero area
            xs = $urandom_range(0, 65535) - 32768;
            vertex(xs, xs, $urandom_range(0, 65535) - 32768, $urandom_range(255),
                   $urandom_range(255), $urandom_range(255), $urandom_range(255));
          end
          sent++;
          // broken sequences: a read or a clear between vertices
          if (k < 2 && $urandom_range(19) == 0) begin
            if ($urandom_range(3) == 0) clear_all();
            else read_px(spot_x, spot_y);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_view(64, 64);

    // reset contents at the corners
    read_px(0, 0);
    read_px(63, 63);
    // clockwise triangle, depth and colour extremes
    vertex(0, 0, -32768, 255, 0, 255, 0);
    vertex(64, 0, 0, 0, 255, 0, 255);
    vertex(0, 64, 32767, 128, 128, 128, 128);
    read_px(0, 0);
    read_px(1, 1);
    // same spot counter-clockwise at maximum depth, never written
    vertex(0, 64, 32767, 1, 2, 3, 4);
    vertex(64, 0, 32767, 1, 2, 3, 4);
    vertex(0, 0, 32767, 1, 2, 3, 4);
    // zero area across the whole position range
    vertex(-32768, -32768, 0, 9, 9, 9, 9);
    vertex(32767, 32767, 0, 9, 9, 9, 9);
    vertex(0, 0, 0, 9, 9, 9, 9);
    read_px(2, 1);
    clear_all();
    read_px(0, 0);
    // equal depth is not written a second time
    for (int t = 0; t < 2; t++) begin
      vertex(16, 16, 100, 10 + t, 20, 30, 40);
      vertex(80, 16, 100, 10 + t, 20, 30, 40);
      vertex(16, 80, 100, 10 + t, 20, 30, 40);
    end
    read_px(1, 1);
    settle();

    // random phases under different viewports and idling
    for (int p = 0; p < 6; p++) begin
      send_idle = (p < 2) ? 18 : (p < 4) ? 54 : 0;
      take_idle = (p < 2) ? 54 : (p < 4) ? 18 : 0;
      case (p)
        0: set_view(0, 64);
        1: set_view(1, 1);
        2: set_view(127, 127);
        3: set_view(64, 0);
        4: set_view($urandom_range(1, 64), $urandom_range(1, 64));
        default: set_view(64, 64);
      endcase
      random_mix(285);
      settle();
    end

    repeat (200) @(posedge clk);
    if (frame.errors == 0 && frame.pixels_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // worst case: every triangle filling the whole store with written pixels
  initial begin
    repeat (40) #100_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule

`default_nettype wire

// File: filelist.f
src/trd_pkg.sv
src/triangle_raster_depth_test.sv
src/trd_checker.sv
bench/tb.sv
